// File: rtl/cir_pkg.sv
// ----------------------------------------------------------------------------
// Collision impulse resolver package
// Shared constants and types for the impulse pipeline and its divider.
// ----------------------------------------------------------------------------
package cir_pkg;

    // Unit value 1.0 in Q2.16.
    localparam logic [17:0] ONE_Q16 = 18'd65536;

    // Reset value of the restitution register (1.0 in Q1.16).
    localparam logic [16:0] RESTITUTION_RESET = 17'd65536;

    // One quotient bit is resolved per divider stage.
    localparam int DIV_STEPS = 32;

    // Side data line that runs next to the divider. The projection stage runs
    // beside the first divider step, so the line covers the remaining steps.
    localparam int SIDE_DEPTH = DIV_STEPS - 1;

    // Per-pair data that travels beside the divider.
    typedef struct packed {
        logic        ia;
        logic        ib;
        logic        zden;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] t_x;
        logic [63:0] t_y;
        logic        neg_x;
        logic        neg_y;
    } side_t;

endpackage

// File: rtl/cir_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Divides a 64-bit numerator by a 33-bit denominator, one quotient bit per
// stage. The quotient must fit in 32 bits (numerator high half below the
// denominator). All stages advance together on the enable.
// ----------------------------------------------------------------------------
module cir_div
    import cir_pkg::*;
(
    input  logic        clk,
    input  logic        adv,
    input  logic [63:0] num,
    input  logic [32:0] den,
    output logic [31:0] quo
);

    logic [32:0] rem_reg [DIV_STEPS];
    logic [31:0] low_reg [DIV_STEPS];
    logic [31:0] quo_reg [DIV_STEPS];
    logic [32:0] den_reg [DIV_STEPS];

    genvar s;
    generate
        for (s = 0; s < DIV_STEPS; s++)
        begin : g_step
            logic [32:0] rem_in;
            logic [31:0] low_in;
            logic [31:0] quo_in;
            logic [32:0] den_in;
            logic [33:0] trial;
            logic [33:0] diff;
            logic        take;

            // Stage inputs come from the ports for the first step.
            if (s == 0)
            begin : g_first
                assign rem_in = {1'b0, num[63:32]};
                assign low_in = num[31:0];
                assign quo_in = '0;
                assign den_in = den;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[s-1];
                assign low_in = low_reg[s-1];
                assign quo_in = quo_reg[s-1];
                assign den_in = den_reg[s-1];
            end

            // Shift in the next numerator bit and try a subtraction.
            assign trial = {rem_in, low_in[31]};
            assign diff  = trial - {1'b0, den_in};
            assign take  = (trial >= {1'b0, den_in});

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[s] <= take ? diff[32:0] : trial[32:0];
                    low_reg[s] <= {low_in[30:0], 1'b0};
                    quo_reg[s] <= {quo_in[30:0], take};
                    den_reg[s] <= den_in;
                end
            end
        end
    endgenerate

    assign quo = quo_reg[DIV_STEPS-1];

endmodule

// File: rtl/collision_impulse_resolver_top.sv
// Path of a pair: stage A, divider beside stage B and side line, stages E to H, output.
// Throughput: one pair per unstalled cycle; the 32-stage reduced-mass divider sets depth.
// The whole pipeline advances together and holds while a finished result is stalled.
// Reset clears all valid bits and loads restitution with 1.0; payload is not reset.
// ----------------------------------------------------------------------------
// Collision impulse resolver
// Computes the impulse exchange for one colliding pair of 2D bodies per cycle unless stalled.
// ----------------------------------------------------------------------------
module collision_impulse_resolver_top
    import cir_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [16:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        mass_a,
    input  logic               immovable_a,
    input  logic [31:0]        mass_b,
    input  logic               immovable_b,
    input  logic signed [31:0] vel_a_x,
    input  logic signed [31:0] vel_a_y,
    input  logic signed [31:0] vel_b_x,
    input  logic signed [31:0] vel_b_y,
    input  logic signed [15:0] axis_x,
    input  logic signed [15:0] axis_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] impulse_a_x,
    output logic signed [31:0] impulse_a_y,
    output logic signed [31:0] impulse_b_x,
    output logic signed [31:0] impulse_b_y,
    output logic               saturated
);

    // Clip a rounded magnitude with its sign into a signed 32-bit value.
    function automatic logic [32:0] clip(input logic [52:0] mag, input logic neg);
        logic [32:0] res;
        if (neg)
        begin
            if (mag > 53'h80000000)
                res = {1'b1, 32'h80000000};
            else
                res = {1'b0, 32'(~mag[31:0] + 32'd1)};
        end
        else
        begin
            if (mag > 53'h7FFFFFFF)
                res = {1'b1, 32'h7FFFFFFF};
            else
                res = {1'b0, mag[31:0]};
        end
        return res;
    endfunction

    logic adv;
    logic [16:0] restitution_reg;

    // Pipeline advance: move whenever the output register is free or taken.
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    // Restitution register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            restitution_reg <= RESTITUTION_RESET;
        else if (cfg_we)
            restitution_reg <= cfg_wdata;
    end

    // Valid bits.
    logic a_v_reg, b_v_reg, e_v_reg, f_v_reg, g_v_reg, h_v_reg, o_v_reg;
    logic [SIDE_DEPTH-1:0] side_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg    <= 1'b0;
            b_v_reg    <= 1'b0;
            side_v_reg <= '0;
            e_v_reg    <= 1'b0;
            f_v_reg    <= 1'b0;
            g_v_reg    <= 1'b0;
            h_v_reg    <= 1'b0;
            o_v_reg    <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg    <= in_valid;
            b_v_reg    <= a_v_reg;
            side_v_reg <= {side_v_reg[SIDE_DEPTH-2:0], b_v_reg};
            e_v_reg    <= side_v_reg[SIDE_DEPTH-1];
            f_v_reg    <= e_v_reg;
            g_v_reg    <= f_v_reg;
            h_v_reg    <= g_v_reg;
            o_v_reg    <= h_v_reg;
        end
    end

    // Stage A: velocity differences, mass product and mass sum.
    logic               a_ia_reg, a_ib_reg;
    logic [31:0]        a_ma_reg, a_mb_reg;
    logic signed [32:0] a_dvx_reg, a_dvy_reg;
    logic signed [15:0] a_nx_reg, a_ny_reg;
    logic [63:0]        a_mm_reg;
    logic [32:0]        a_den_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_ia_reg  <= immovable_a;
            a_ib_reg  <= immovable_b;
            a_ma_reg  <= mass_a;
            a_mb_reg  <= mass_b;
            a_dvx_reg <= {vel_b_x[31], vel_b_x} - {vel_a_x[31], vel_a_x};
            a_dvy_reg <= {vel_b_y[31], vel_b_y} - {vel_a_y[31], vel_a_y};
            a_nx_reg  <= axis_x;
            a_ny_reg  <= axis_y;
            a_mm_reg  <= 64'(mass_a) * 64'(mass_b);
            a_den_reg <= {1'b0, mass_a} + {1'b0, mass_b};
        end
    end

    // Divider for the reduced mass.
    logic [31:0] div_quo;

    cir_div u_div (
        .clk (clk),
        .adv (adv),
        .num (a_mm_reg),
        .den (a_den_reg),
        .quo (div_quo)
    );

    // Stage B: projections of the velocity difference on the axis.
    logic               b_ia_reg, b_ib_reg, b_zden_reg;
    logic [31:0]        b_ma_reg, b_mb_reg;
    logic signed [48:0] b_px_reg, b_py_reg;
    logic signed [15:0] b_nx_reg, b_ny_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_ia_reg   <= a_ia_reg;
            b_ib_reg   <= a_ib_reg;
            b_zden_reg <= (a_den_reg == '0);
            b_ma_reg   <= a_ma_reg;
            b_mb_reg   <= a_mb_reg;
            b_px_reg   <= 49'(a_dvx_reg) * 49'(a_nx_reg);
            b_py_reg   <= 49'(a_dvy_reg) * 49'(a_ny_reg);
            b_nx_reg   <= a_nx_reg;
            b_ny_reg   <= a_ny_reg;
        end
    end

    // Closing speed magnitude times each axis magnitude, with the signs.
    logic signed [49:0] c_d;
    logic [49:0]        c_dmag;
    logic [15:0]        c_nmag_x, c_nmag_y;
    logic [65:0]        c_t_x, c_t_y;
    side_t              side_next;

    always_comb
    begin
        c_d      = {b_px_reg[48], b_px_reg} + {b_py_reg[48], b_py_reg};
        c_dmag   = c_d[49] ? 50'(-c_d) : 50'(c_d);
        c_nmag_x = b_nx_reg[15] ? 16'(-b_nx_reg) : 16'(b_nx_reg);
        c_nmag_y = b_ny_reg[15] ? 16'(-b_ny_reg) : 16'(b_ny_reg);
        c_t_x    = 66'(c_dmag) * 66'(c_nmag_x);
        c_t_y    = 66'(c_dmag) * 66'(c_nmag_y);

        side_next.ia    = b_ia_reg;
        side_next.ib    = b_ib_reg;
        side_next.zden  = b_zden_reg;
        side_next.ma    = b_ma_reg;
        side_next.mb    = b_mb_reg;
        side_next.t_x   = c_t_x[63:0];
        side_next.t_y   = c_t_y[63:0];
        side_next.neg_x = c_d[49] ^ b_nx_reg[15];
        side_next.neg_y = c_d[49] ^ b_ny_reg[15];
    end

    // Side line that waits for the divider.
    side_t side_reg [SIDE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_next;
            for (int i = 1; i < SIDE_DEPTH; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Stage E: effective mass and scale factor k.
    side_t       side_out;
    logic [31:0] meff;
    logic        e_ia_reg, e_ib_reg, e_neg_x_reg, e_neg_y_reg;
    logic [63:0] e_t_x_reg, e_t_y_reg;
    logic [49:0] e_k_reg;

    always_comb
    begin
        side_out = side_reg[SIDE_DEPTH-1];
        if (side_out.ia && side_out.ib)
            meff = '0;
        else if (side_out.ia)
            meff = side_out.mb;
        else if (side_out.ib)
            meff = side_out.ma;
        else if (side_out.zden)
            meff = '0;
        else
            meff = div_quo;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_ia_reg    <= side_out.ia;
            e_ib_reg    <= side_out.ib;
            e_neg_x_reg <= side_out.neg_x;
            e_neg_y_reg <= side_out.neg_y;
            e_t_x_reg   <= side_out.t_x;
            e_t_y_reg   <= side_out.t_y;
            e_k_reg     <= 50'(meff) * 50'(ONE_Q16 + 18'(restitution_reg));
        end
    end

    // Stage F: partial products of k times each component factor.
    logic        f_ia_reg, f_ib_reg, f_neg_x_reg, f_neg_y_reg;
    logic [56:0] f_x00_reg, f_x01_reg, f_x10_reg, f_x11_reg;
    logic [56:0] f_y00_reg, f_y01_reg, f_y10_reg, f_y11_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_ia_reg    <= e_ia_reg;
            f_ib_reg    <= e_ib_reg;
            f_neg_x_reg <= e_neg_x_reg;
            f_neg_y_reg <= e_neg_y_reg;
            f_x00_reg   <= 57'(e_k_reg[24:0]) * 57'(e_t_x_reg[31:0]);
            f_x01_reg   <= 57'(e_k_reg[24:0]) * 57'(e_t_x_reg[63:32]);
            f_x10_reg   <= 57'(e_k_reg[49:25]) * 57'(e_t_x_reg[31:0]);
            f_x11_reg   <= 57'(e_k_reg[49:25]) * 57'(e_t_x_reg[63:32]);
            f_y00_reg   <= 57'(e_k_reg[24:0]) * 57'(e_t_y_reg[31:0]);
            f_y01_reg   <= 57'(e_k_reg[24:0]) * 57'(e_t_y_reg[63:32]);
            f_y10_reg   <= 57'(e_k_reg[49:25]) * 57'(e_t_y_reg[31:0]);
            f_y11_reg   <= 57'(e_k_reg[49:25]) * 57'(e_t_y_reg[63:32]);
        end
    end

    // Stage G: combine partial products sharing the same k half.
    logic        g_ia_reg, g_ib_reg, g_neg_x_reg, g_neg_y_reg;
    logic [89:0] g_x0_reg, g_x1_reg, g_y0_reg, g_y1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_ia_reg    <= f_ia_reg;
            g_ib_reg    <= f_ib_reg;
            g_neg_x_reg <= f_neg_x_reg;
            g_neg_y_reg <= f_neg_y_reg;
            g_x0_reg    <= 90'(f_x00_reg) + (90'(f_x01_reg) << 32);
            g_x1_reg    <= 90'(f_x10_reg) + (90'(f_x11_reg) << 32);
            g_y0_reg    <= 90'(f_y00_reg) + (90'(f_y01_reg) << 32);
            g_y1_reg    <= 90'(f_y10_reg) + (90'(f_y11_reg) << 32);
        end
    end

    // Stage H: full product, rounded to nearest at bit 60.
    logic [114:0] h_sum_x, h_sum_y;
    logic         h_ia_reg, h_ib_reg, h_neg_x_reg, h_neg_y_reg;
    logic [52:0]  h_mag_x_reg, h_mag_y_reg;

    always_comb
    begin
        h_sum_x = 115'(g_x0_reg) + (115'(g_x1_reg) << 25) + (115'(1) << 59);
        h_sum_y = 115'(g_y0_reg) + (115'(g_y1_reg) << 25) + (115'(1) << 59);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_ia_reg    <= g_ia_reg;
            h_ib_reg    <= g_ib_reg;
            h_neg_x_reg <= g_neg_x_reg;
            h_neg_y_reg <= g_neg_y_reg;
            h_mag_x_reg <= h_sum_x[112:60];
            h_mag_y_reg <= h_sum_y[112:60];
        end
    end

    // Output stage: sign, saturation and immovable bodies.
    logic [32:0] cl_ax, cl_ay, cl_bx, cl_by;
    logic        sat_next;
    logic [31:0] o_ax_reg, o_ay_reg, o_bx_reg, o_by_reg;
    logic        o_sat_reg;

    always_comb
    begin
        cl_ax    = clip(h_mag_x_reg, h_neg_x_reg);
        cl_ay    = clip(h_mag_y_reg, h_neg_y_reg);
        cl_bx    = clip(h_mag_x_reg, !h_neg_x_reg);
        cl_by    = clip(h_mag_y_reg, !h_neg_y_reg);
        sat_next = (!h_ia_reg && (cl_ax[32] || cl_ay[32]))
                || (!h_ib_reg && (cl_bx[32] || cl_by[32]));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_ax_reg  <= h_ia_reg ? 32'd0 : cl_ax[31:0];
            o_ay_reg  <= h_ia_reg ? 32'd0 : cl_ay[31:0];
            o_bx_reg  <= h_ib_reg ? 32'd0 : cl_bx[31:0];
            o_by_reg  <= h_ib_reg ? 32'd0 : cl_by[31:0];
            o_sat_reg <= sat_next;
        end
    end

    assign out_valid   = o_v_reg;
    assign impulse_a_x = o_ax_reg;
    assign impulse_a_y = o_ay_reg;
    assign impulse_b_x = o_bx_reg;
    assign impulse_b_y = o_by_reg;
    assign saturated   = o_sat_reg;

endmodule
